// ----- src/ctb_pkg.sv -----
// Shared types, constants and arithmetic parameters of the cycle time base.
package ctb_pkg;

    // Opcode of an input beat
    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_SET    = 1'b1
    } t_op;

    // Slice counter
    localparam int SLICE_WRAP = 15015;
    localparam int SLICE_W    = $clog2(SLICE_WRAP + 2);

    // Modulo flags: divisors above two, kept as residue counters
    localparam int NUM_DIV = 5;
    localparam int DIV_W   = 4;
    localparam logic [DIV_W-1:0] DIVISORS [NUM_DIV] = '{
        DIV_W'(3), DIV_W'(5), DIV_W'(7), DIV_W'(11), DIV_W'(13)
    };

    // Period accumulators
    localparam int ACCUM_BITS  = 40;
    localparam int ACC_W       = ACCUM_BITS;
    localparam int NUM_PERIODS = 7;
    localparam int SEC_PULSE   = 2;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] PERIODS [NUM_PERIODS] = '{
        ACC_W'(64'd10000),    ACC_W'(64'd100000),   ACC_W'(64'd1000000),
        ACC_W'(64'd6000000),  ACC_W'(64'd10000000), ACC_W'(64'd60000000),
        ACC_W'(64'd100000000)
    };

    // Time of day
    localparam int SEC_LIMIT  = 60;
    localparam int MIN_LIMIT  = 60;
    localparam int HOUR_LIMIT = 24;

    // Millisecond readout: acc / 1000 = (acc >> 3) / 125, split in two halves
    localparam int MILLIS_W = 23;
    localparam int MS_SHIFT = 3;
    localparam int QDIV     = 125;
    localparam int QDIV_W   = $clog2(QDIV);
    localparam int X_W      = ACC_W - MS_SHIFT;
    localparam int LO_W     = 20;
    localparam int HI_W     = X_W - LO_W;
    localparam int HI_K     = HI_W + QDIV_W;
    localparam longint unsigned HI_M = ((64'd1 << HI_K) + QDIV - 1) / QDIV;
    localparam int HI_M_W   = HI_W + 1;
    localparam int PRODH_W  = HI_W + HI_M_W;
    localparam int Y_W      = QDIV_W + LO_W;
    localparam int Y_K      = Y_W + QDIV_W;
    localparam longint unsigned Y_M = ((64'd1 << Y_K) + QDIV - 1) / QDIV;
    localparam int Y_M_W    = Y_W + 1;
    localparam int PRODY_W  = Y_W + Y_M_W;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] system_time;
        logic [5:0]  set_seconds;
        logic [5:0]  set_minutes;
        logic [4:0]  set_hours;
        logic [31:0] set_days;
    } t_in_beat;

    typedef struct packed {
        t_op         opcode;
        logic        first;
        logic [31:0] cycle_delta;
        logic [31:0] cycle_total;
        logic [5:0]  set_seconds;
        logic [5:0]  set_minutes;
        logic [4:0]  set_hours;
        logic [31:0] set_days;
    } t_stamp_beat;

    typedef struct packed {
        logic [31:0]      cycle_delta;
        logic [31:0]      cycle_total;
        logic [6:0]       slice_flags;
        logic [6:0]       pulse_flags;
        logic [6:0]       toggle_flags;
        logic [31:0]      rate_per_second;
        logic [ACC_W-1:0] acc_1s;
        logic [5:0]       clock_seconds;
        logic [5:0]       clock_minutes;
        logic [4:0]       clock_hours;
        logic [31:0]      clock_days;
    } t_core_beat;

    typedef struct packed {
        logic [31:0]         cycle_delta;
        logic [31:0]         cycle_total;
        logic [6:0]          slice_flags;
        logic [6:0]          pulse_flags;
        logic [6:0]          toggle_flags;
        logic [31:0]         rate_per_second;
        logic [MILLIS_W-1:0] millis;
        logic [5:0]          clock_seconds;
        logic [5:0]          clock_minutes;
        logic [4:0]          clock_hours;
        logic [31:0]         clock_days;
    } t_out_beat;

endpackage

// ----- src/ctb_stamp.sv -----
// Input register and timestamp stage: cycle delta, cycle count, first-sample tracking.
module ctb_stamp import ctb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_beat    i_beat,
    output logic        o_valid,
    input  logic        i_ready,
    output t_stamp_beat o_beat
);

    logic        r_in_valid;
    t_in_beat    r_in;
    logic        r_s1_valid;
    t_stamp_beat r_s1;

    logic        r_first, n_first;
    logic [31:0] r_last, n_last;
    logic [31:0] r_delta, n_delta;
    logic [31:0] r_total, n_total;

    logic        w_s1_ready;
    logic        w_move;
    t_stamp_beat w_beat;

    // Handshake through the input register and the stage register
    assign w_s1_ready = !r_s1_valid || i_ready;
    assign w_move     = r_in_valid && w_s1_ready;
    assign o_ready    = !r_in_valid || w_move;
    assign o_valid    = r_s1_valid;
    assign o_beat     = r_s1;

    // Measure the cycle time; hold the old delta when time runs backwards
    always_comb begin
        n_first = r_first;
        n_last  = r_last;
        n_delta = r_delta;
        n_total = r_total;
        if (w_move && (r_in.opcode == OP_SAMPLE)) begin
            if (r_first) begin
                n_first = 1'b0;
                n_delta = '0;
                n_total = '0;
            end else begin
                if (r_in.system_time >= r_last) begin
                    n_delta = r_in.system_time - r_last;
                end
                n_total = r_total + 32'd1;
            end
            n_last = r_in.system_time;
        end
    end

    always_comb begin
        w_beat.opcode      = r_in.opcode;
        w_beat.first       = r_first;
        w_beat.cycle_delta = n_delta;
        w_beat.cycle_total = n_total;
        w_beat.set_seconds = r_in.set_seconds;
        w_beat.set_minutes = r_in.set_minutes;
        w_beat.set_hours   = r_in.set_hours;
        w_beat.set_days    = r_in.set_days;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_first    <= 1'b1;
            r_last     <= '0;
            r_delta    <= '0;
            r_total    <= 32'd1;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_s1_valid <= 1'b1;
            end else if (i_ready) begin
                r_s1_valid <= 1'b0;
            end
            r_first <= n_first;
            r_last  <= n_last;
            r_delta <= n_delta;
            r_total <= n_total;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_beat;
        end
        if (w_move) begin
            r_s1 <= w_beat;
        end
    end

endmodule

// ----- src/ctb_core.sv -----
// Core stage: slice flags, period accumulators, pulses, rate and time of day.
module ctb_core import ctb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_stamp_beat i_beat,
    output logic        o_valid,
    input  logic        i_ready,
    output t_core_beat  o_beat
);

    logic             r_s2_valid;
    t_core_beat       r_s2;

    logic [SLICE_W-1:0] r_slice, n_slice;
    logic [DIV_W-1:0]   r_res [NUM_DIV];
    logic [DIV_W-1:0]   n_res [NUM_DIV];
    logic [ACC_W-1:0]   r_acc [NUM_PERIODS];
    logic [ACC_W-1:0]   n_acc [NUM_PERIODS];
    logic [6:0]         r_slice_flags, n_slice_flags;
    logic [6:0]         r_pulse, n_pulse;
    logic [6:0]         r_toggle, n_toggle;
    logic [31:0]        r_tally, n_tally;
    logic [31:0]        r_rate, n_rate;
    logic [5:0]         r_sec, n_sec;
    logic [5:0]         r_min, n_min;
    logic [4:0]         r_hour, n_hour;
    logic [31:0]        r_day, n_day;

    logic [ACC_W-1:0]   w_lane_acc [NUM_PERIODS];
    logic [6:0]         w_lane_hit;
    logic               w_accept;
    t_core_beat         w_beat;

    assign o_ready  = !r_s2_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_s2_valid;
    assign o_beat   = r_s2;

    // Saturating add of the delta, then take off one period if reached
    always_comb begin
        logic [ACC_W:0]   sum;
        logic [ACC_W+1:0] diff;
        for (int i = 0; i < NUM_PERIODS; i++) begin
            sum  = {1'b0, r_acc[i]} + (ACC_W+1)'(i_beat.cycle_delta);
            diff = {1'b0, sum} - {2'b00, PERIODS[i]};
            if (sum[ACC_W]) begin
                w_lane_acc[i] = ACC_MAX - PERIODS[i];
                w_lane_hit[i] = 1'b1;
            end else if (!diff[ACC_W+1]) begin
                w_lane_acc[i] = diff[ACC_W-1:0];
                w_lane_hit[i] = 1'b1;
            end else begin
                w_lane_acc[i] = sum[ACC_W-1:0];
                w_lane_hit[i] = 1'b0;
            end
        end
    end

    // Next state for one accepted beat
    always_comb begin
        logic [6:0] sec_inc;
        logic [6:0] min_inc;
        logic [5:0] hour_inc;
        n_slice       = r_slice;
        n_res         = r_res;
        n_acc         = r_acc;
        n_slice_flags = r_slice_flags;
        n_pulse       = r_pulse;
        n_toggle      = r_toggle;
        n_tally       = r_tally;
        n_rate        = r_rate;
        n_sec         = r_sec;
        n_min         = r_min;
        n_hour        = r_hour;
        n_day         = r_day;
        sec_inc       = {1'b0, r_sec} + 7'd1;
        min_inc       = {1'b0, r_min} + 7'd1;
        hour_inc      = {1'b0, r_hour} + 6'd1;
        if (w_accept) begin
            unique case (i_beat.opcode)
                OP_SAMPLE: begin
                    if (i_beat.first) begin
                        // first sample: restart counters, clock and accumulators
                        n_slice = '0;
                        for (int i = 0; i < NUM_DIV; i++) begin
                            n_res[i] = '0;
                        end
                        for (int i = 0; i < NUM_PERIODS; i++) begin
                            n_acc[i] = '0;
                        end
                        n_tally = '0;
                        n_rate  = 32'd1;
                        n_sec   = '0;
                        n_min   = '0;
                        n_hour  = '0;
                        n_day   = '0;
                    end else begin
                        // advance slice count and its residues
                        if (r_slice > SLICE_W'(SLICE_WRAP)) begin
                            n_slice = SLICE_W'(1);
                            for (int i = 0; i < NUM_DIV; i++) begin
                                n_res[i] = DIV_W'(1);
                            end
                        end else begin
                            n_slice = r_slice + SLICE_W'(1);
                            for (int i = 0; i < NUM_DIV; i++) begin
                                n_res[i] = (r_res[i] == DIVISORS[i] - DIV_W'(1)) ?
                                           '0 : r_res[i] + DIV_W'(1);
                            end
                        end
                        n_slice_flags[0] = !n_slice[0];
                        n_slice_flags[1] = n_slice[0];
                        for (int i = 0; i < NUM_DIV; i++) begin
                            n_slice_flags[i+2] = (n_res[i] == '0);
                        end
                        // period pulses and toggles
                        n_acc    = w_lane_acc;
                        n_pulse  = w_lane_hit;
                        n_toggle = r_toggle ^ w_lane_hit;
                        // one second: latch the rate and step the clock
                        if (w_lane_hit[SEC_PULSE]) begin
                            n_rate  = r_tally;
                            n_tally = 32'd1;
                            if (sec_inc >= 7'(SEC_LIMIT)) begin
                                n_sec = '0;
                                if (min_inc >= 7'(MIN_LIMIT)) begin
                                    n_min = '0;
                                    if (hour_inc >= 6'(HOUR_LIMIT)) begin
                                        n_hour = '0;
                                        n_day  = r_day + 32'd1;
                                    end else begin
                                        n_hour = hour_inc[4:0];
                                    end
                                end else begin
                                    n_min = min_inc[5:0];
                                end
                            end else begin
                                n_sec = sec_inc[5:0];
                            end
                        end else begin
                            n_tally = r_tally + 32'd1;
                        end
                    end
                end
                OP_SET: begin
                    n_sec  = i_beat.set_seconds;
                    n_min  = i_beat.set_minutes;
                    n_hour = i_beat.set_hours;
                    n_day  = i_beat.set_days;
                end
                default: begin
                    n_sec = r_sec;
                end
            endcase
        end
    end

    always_comb begin
        w_beat.cycle_delta     = i_beat.cycle_delta;
        w_beat.cycle_total     = i_beat.cycle_total;
        w_beat.slice_flags     = n_slice_flags;
        w_beat.pulse_flags     = n_pulse;
        w_beat.toggle_flags    = n_toggle;
        w_beat.rate_per_second = n_rate;
        w_beat.acc_1s          = n_acc[SEC_PULSE];
        w_beat.clock_seconds   = n_sec;
        w_beat.clock_minutes   = n_min;
        w_beat.clock_hours     = n_hour;
        w_beat.clock_days      = n_day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid    <= 1'b0;
            r_slice       <= '0;
            for (int i = 0; i < NUM_DIV; i++) begin
                r_res[i] <= '0;
            end
            for (int i = 0; i < NUM_PERIODS; i++) begin
                r_acc[i] <= '0;
            end
            r_slice_flags <= '0;
            r_pulse       <= '0;
            r_toggle      <= '0;
            r_tally       <= '0;
            r_rate        <= 32'd1;
            r_sec         <= '0;
            r_min         <= '0;
            r_hour        <= '0;
            r_day         <= '0;
        end else begin
            if (w_accept) begin
                r_s2_valid <= 1'b1;
            end else if (i_ready) begin
                r_s2_valid <= 1'b0;
            end
            r_slice       <= n_slice;
            r_res         <= n_res;
            r_acc         <= n_acc;
            r_slice_flags <= n_slice_flags;
            r_pulse       <= n_pulse;
            r_toggle      <= n_toggle;
            r_tally       <= n_tally;
            r_rate        <= n_rate;
            r_sec         <= n_sec;
            r_min         <= n_min;
            r_hour        <= n_hour;
            r_day         <= n_day;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s2 <= w_beat;
        end
    end

endmodule

// ----- src/ctb_millis.sv -----
// Millisecond readout pipeline (one-second accumulator / 1000) and output register.
module ctb_millis import ctb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_core_beat i_beat,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_beat  o_beat
);

    logic               r_s3_valid;
    t_core_beat         r_s3_beat;
    logic [PRODH_W-1:0] r_prod_h;
    logic [HI_W-1:0]    r_hi;
    logic [LO_W-1:0]    r_lo;

    logic               r_s4_valid;
    t_core_beat         r_s4_beat;
    logic [HI_W-1:0]    r_qh;
    logic [Y_W-1:0]     r_y;

    logic               r_out_valid;
    t_out_beat          r_out;

    logic               w_out_ready;
    logic               w_s4_ready;
    logic               w_mv3;
    logic               w_mv4;
    logic               w_mvo;
    logic [X_W-1:0]     w_x;
    logic [HI_W-1:0]    w_qh;
    logic [HI_W-1:0]    w_rh;
    logic [PRODY_W-1:0] w_prod_y;
    logic [LO_W-1:0]    w_qy;
    t_out_beat          w_out;

    // Stage handshake
    assign w_out_ready = !r_out_valid || i_ready;
    assign w_s4_ready  = !r_s4_valid || w_out_ready;
    assign o_ready     = !r_s3_valid || w_s4_ready;
    assign w_mv3       = i_valid && o_ready;
    assign w_mv4       = r_s3_valid && w_s4_ready;
    assign w_mvo       = r_s4_valid && w_out_ready;
    assign o_valid     = r_out_valid;
    assign o_beat      = r_out;

    // Quotient of the upper half by 125 through a reciprocal, then its remainder
    assign w_x  = i_beat.acc_1s[ACC_W-1:MS_SHIFT];
    assign w_qh = HI_W'(r_prod_h >> HI_K);
    assign w_rh = r_hi - HI_W'(w_qh * HI_W'(QDIV));

    // Remainder joined with the lower half, divided by 125 the same way
    assign w_prod_y = PRODY_W'(r_y) * PRODY_W'(Y_M);
    assign w_qy     = LO_W'(w_prod_y >> Y_K);

    always_comb begin
        w_out.cycle_delta     = r_s4_beat.cycle_delta;
        w_out.cycle_total     = r_s4_beat.cycle_total;
        w_out.slice_flags     = r_s4_beat.slice_flags;
        w_out.pulse_flags     = r_s4_beat.pulse_flags;
        w_out.toggle_flags    = r_s4_beat.toggle_flags;
        w_out.rate_per_second = r_s4_beat.rate_per_second;
        w_out.millis          = MILLIS_W'({r_qh, w_qy});
        w_out.clock_seconds   = r_s4_beat.clock_seconds;
        w_out.clock_minutes   = r_s4_beat.clock_minutes;
        w_out.clock_hours     = r_s4_beat.clock_hours;
        w_out.clock_days      = r_s4_beat.clock_days;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mv3) begin
                r_s3_valid <= 1'b1;
            end else if (w_mv4) begin
                r_s3_valid <= 1'b0;
            end
            if (w_mv4) begin
                r_s4_valid <= 1'b1;
            end else if (w_mvo) begin
                r_s4_valid <= 1'b0;
            end
            if (w_mvo) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_mv3) begin
            r_s3_beat <= i_beat;
            r_hi      <= w_x[X_W-1:LO_W];
            r_lo      <= w_x[LO_W-1:0];
            r_prod_h  <= PRODH_W'(w_x[X_W-1:LO_W]) * PRODH_W'(HI_M);
        end
        if (w_mv4) begin
            r_s4_beat <= r_s3_beat;
            r_qh      <= w_qh;
            r_y       <= {w_rh[QDIV_W-1:0], r_lo};
        end
        if (w_mvo) begin
            r_out <= w_out;
        end
    end

endmodule

// ----- src/cycle_time_base.sv -----
// Top level of the scan-cycle time base.
//
// Each input beat is a microsecond timestamp sample or a time-of-day preset, and
// each gives exactly one result beat with the cycle time, cycle count, slice and
// period flags, cycles per second, the one-second accumulator in milliseconds and
// the time of day. The block takes one beat per clock while the output is not
// stalled, and each beat passes through its register chain in order: input
// register, timestamp stage, core stage (slice counter, seven 40-bit period
// accumulators, clock), two stages of the divide-by-1000 reciprocal multiplies,
// and the output register. Every stage holds its beat while the one after it is
// full, so a waiting result stalls input only once all stages are occupied.
module cycle_time_base import ctb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_item
);

    logic        w_s1_valid;
    logic        w_s1_ready;
    t_stamp_beat w_s1_beat;
    logic        w_s2_valid;
    logic        w_s2_ready;
    t_core_beat  w_s2_beat;

    ctb_stamp u_stamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_item),
        .o_valid (w_s1_valid),
        .i_ready (w_s1_ready),
        .o_beat  (w_s1_beat)
    );

    ctb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_beat  (w_s1_beat),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_beat  (w_s2_beat)
    );

    ctb_millis u_millis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_beat  (w_s2_beat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_item)
    );

endmodule
